@@ sv/foc_current_loop_assert.svh @@
// ----------------------------------------------------------------------------
// foc current loop assertion macros
// shared concurrent assertion forms for the current loop modules
// ----------------------------------------------------------------------------
`ifndef FOC_CURRENT_LOOP_ASSERT_SVH
`define FOC_CURRENT_LOOP_ASSERT_SVH

// same-cycle implication
`define FOC_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("foc current loop assertion failed");

// next-cycle implication
`define FOC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("foc current loop assertion failed");

`endif

@@ sv/foc_pkg.sv @@
// ----------------------------------------------------------------------------
// foc_pkg
// types and constants shared by the current loop controller and datapath
// ----------------------------------------------------------------------------
package foc_pkg;

   localparam logic [63:0] INV_SQRT3_Q32 = 64'd2479700524;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THREE_PHASE_MODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KP_D             = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KI_D             = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_D          = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KP_Q             = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KI_Q             = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_Q          = 3'd6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_RECON,
      OP_CLARKE,
      OP_MUL,
      OP_ACC,
      OP_ERR,
      OP_DIFF,
      OP_SUM,
      OP_CLAMP
   } op_type;

   typedef enum logic [3:0] {
      STEP_BETA  = 4'd0,
      STEP_AL_CS = 4'd1,
      STEP_BE_SN = 4'd2,
      STEP_BE_CS = 4'd3,
      STEP_AL_SN = 4'd4,
      STEP_KP_D  = 4'd5,
      STEP_KI_D  = 4'd6,
      STEP_KP_Q  = 4'd7,
      STEP_KI_Q  = 4'd8,
      STEP_DD_CS = 4'd9,
      STEP_QD_SN = 4'd10,
      STEP_QD_CS = 4'd11,
      STEP_DD_SN = 4'd12
   } step_type;

   typedef struct packed {
      op_type   op;
      step_type step;
   } cmd_type;

endpackage

@@ sv/foc_current_loop.sv @@
// ----------------------------------------------------------------------------
// foc_current_loop
// field-oriented current loop: clarke, park, two pi regulators, inverse park
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one control period (phase currents, sector, angle sine and
//   cosine, d and q targets); a transaction moves when req_valid and
//   req_ready are both high. req_ready is high only while the sequencer idles.
//   rsp_* carries the inverse park drives, measured d/q currents and the
//   clamped regulator outputs, held in output registers until rsp_ready.
//   csr_* writes gains, limits and three-phase mode; the user must do so
//   only while the block is idle, as the block does not enforce it.
//   transactions do not overlap. the thirteen products share one registered
//   32x32 multiplier, each a multiply step then an accumulate step, beside
//   the reconstruction, clarke sum, error, difference, sum and clamp steps.
//   a stalled receiver does not block the next transaction until its final
//   step, which waits for the output registers to drain.
//   synchronous reset clears the configuration, the regulator accumulators
//   and previous errors, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module foc_current_loop #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [31:0]                   req_phase_a,
   input  logic signed [31:0]                   req_phase_b,
   input  logic signed [31:0]                   req_phase_c,
   input  logic [2:0]                           req_sector,
   input  logic signed [31:0]                   req_angle_sine,
   input  logic signed [31:0]                   req_angle_cosine,
   input  logic signed [31:0]                   req_target_d,
   input  logic signed [31:0]                   req_target_q,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_alpha_drive,
   output logic signed [31:0]                   rsp_beta_drive,
   output logic signed [31:0]                   rsp_d_current,
   output logic signed [31:0]                   rsp_q_current,
   output logic signed [31:0]                   rsp_d_drive,
   output logic signed [31:0]                   rsp_q_drive,
   input  logic                                 csr_write_enable,
   input  logic [foc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [foc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import foc_pkg::*;

   cmd_type cmd;

   foc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   foc_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_phase_a      (req_phase_a),
      .req_phase_b      (req_phase_b),
      .req_phase_c      (req_phase_c),
      .req_sector       (req_sector),
      .req_angle_sine   (req_angle_sine),
      .req_angle_cosine (req_angle_cosine),
      .req_target_d     (req_target_d),
      .req_target_q     (req_target_q),
      .rsp_alpha_drive  (rsp_alpha_drive),
      .rsp_beta_drive   (rsp_beta_drive),
      .rsp_d_current    (rsp_d_current),
      .rsp_q_current    (rsp_q_current),
      .rsp_d_drive      (rsp_d_drive),
      .rsp_q_drive      (rsp_q_drive)
   );

endmodule

@@ sv/foc_control.sv @@
// ----------------------------------------------------------------------------
// foc_control
// sequencer for one current loop transaction: issues datapath commands
// ----------------------------------------------------------------------------
`include "foc_current_loop_assert.svh"

module foc_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output foc_pkg::cmd_type cmd
);
   import foc_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_RECON  = 9'b000000010,
      S_CLARKE = 9'b000000100,
      S_MUL    = 9'b000001000,
      S_ACC    = 9'b000010000,
      S_ERR    = 9'b000100000,
      S_DIFF   = 9'b001000000,
      S_SUM    = 9'b010000000,
      S_CLAMP  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = OP_NONE;
      cmd.step     = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_RECON;
            end
         end
         S_RECON: begin
            cmd.op   = OP_RECON;
            state_in = S_CLARKE;
         end
         S_CLARKE: begin
            cmd.op   = OP_CLARKE;
            step_in  = STEP_BETA;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (step_ff == STEP_DD_SN) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.op       = OP_ACC;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.op = OP_ACC;
               if (step_ff == STEP_AL_SN) begin
                  state_in = S_ERR;
               end else if (step_ff == STEP_KI_Q) begin
                  state_in = S_SUM;
               end else begin
                  step_in  = step_type'(step_ff + 4'd1);
                  state_in = S_MUL;
               end
            end
         end
         S_ERR: begin
            cmd.op   = OP_ERR;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            step_in  = STEP_KP_D;
            state_in = S_MUL;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.op   = OP_CLAMP;
            step_in  = STEP_DD_CS;
            state_in = S_MUL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_BETA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FOC_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready,
                    state_ff == S_RECON)
   `FOC_ASSERT_SAME(a_no_result_overwrite, clock, reset,
                    cmd.op == OP_ACC && cmd.step == STEP_DD_SN,
                    !rsp_valid_ff || rsp_ready)
   `FOC_ASSERT_NEXT(a_clamp_to_inverse_park, clock, reset, state_ff == S_CLAMP,
                    state_ff == S_MUL && step_ff == STEP_DD_CS)
   `FOC_ASSERT_NEXT(a_err_then_diff, clock, reset, state_ff == S_ERR,
                    state_ff == S_DIFF)

endmodule

@@ sv/foc_datapath.sv @@
// ----------------------------------------------------------------------------
// foc_datapath
// operand registers, shared multiplier, regulator state and result registers
// ----------------------------------------------------------------------------
module foc_datapath #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  foc_pkg::cmd_type                     cmd,
   input  logic                                 csr_write_enable,
   input  logic [foc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [foc_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic signed [31:0]                   req_phase_a,
   input  logic signed [31:0]                   req_phase_b,
   input  logic signed [31:0]                   req_phase_c,
   input  logic [2:0]                           req_sector,
   input  logic signed [31:0]                   req_angle_sine,
   input  logic signed [31:0]                   req_angle_cosine,
   input  logic signed [31:0]                   req_target_d,
   input  logic signed [31:0]                   req_target_q,
   output logic signed [31:0]                   rsp_alpha_drive,
   output logic signed [31:0]                   rsp_beta_drive,
   output logic signed [31:0]                   rsp_d_current,
   output logic signed [31:0]                   rsp_q_current,
   output logic signed [31:0]                   rsp_d_drive,
   output logic signed [31:0]                   rsp_q_drive
);
   import foc_pkg::*;

   localparam logic [31:0] K_COEF = 32'(INV_SQRT3_Q32 >> (32 - FRAC_BITS));

   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

   // configuration
   logic               mode_ff;
   logic signed [31:0] kp_d_ff, ki_d_ff, kp_q_ff, ki_q_ff;
   logic [30:0]        limit_d_ff, limit_q_ff;

   // regulator state
   logic signed [31:0] acc_d_ff, acc_q_ff, prev_d_ff, prev_q_ff;

   // working registers
   logic signed [31:0] ia_ff, ib_ff, ic_ff, sn_ff, cs_ff, td_ff, tq_ff;
   logic [2:0]         sector_ff;
   logic signed [31:0] sum_ff, be_ff, t_ff, id_ff, iq_ff;
   logic signed [31:0] err_d_ff, err_q_ff, diff_d_ff, diff_q_ff;
   logic signed [31:0] inc_d_ff, inc_q_ff, o_d_ff, o_q_ff, ad_ff;
   logic signed [63:0] p_ff;

   logic signed [31:0] op_a, op_b, qval;

   function automatic logic signed [31:0] clamp(input logic signed [31:0] o,
                                                input logic [30:0] lim);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = $signed({1'b0, lim});
      lo = -hi;
      if (o > hi) begin
         return hi;
      end else if (o < lo) begin
         return lo;
      end else begin
         return o;
      end
   endfunction

   assign qval = p_ff[FRAC_BITS +: 32];

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.step)
         STEP_BETA: begin
            op_a = sum_ff;
            op_b = $signed(K_COEF);
         end
         STEP_AL_CS: begin
            op_a = ia_ff;
            op_b = cs_ff;
         end
         STEP_BE_SN: begin
            op_a = be_ff;
            op_b = sn_ff;
         end
         STEP_BE_CS: begin
            op_a = be_ff;
            op_b = cs_ff;
         end
         STEP_AL_SN: begin
            op_a = ia_ff;
            op_b = sn_ff;
         end
         STEP_KP_D: begin
            op_a = kp_d_ff;
            op_b = diff_d_ff;
         end
         STEP_KI_D: begin
            op_a = ki_d_ff;
            op_b = err_d_ff;
         end
         STEP_KP_Q: begin
            op_a = kp_q_ff;
            op_b = diff_q_ff;
         end
         STEP_KI_Q: begin
            op_a = ki_q_ff;
            op_b = err_q_ff;
         end
         STEP_DD_CS: begin
            op_a = acc_d_ff;
            op_b = cs_ff;
         end
         STEP_QD_SN: begin
            op_a = acc_q_ff;
            op_b = sn_ff;
         end
         STEP_QD_CS: begin
            op_a = acc_q_ff;
            op_b = cs_ff;
         end
         STEP_DD_SN: begin
            op_a = acc_d_ff;
            op_b = sn_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // configuration and regulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         kp_d_ff    <= '0;
         ki_d_ff    <= '0;
         limit_d_ff <= '0;
         kp_q_ff    <= '0;
         ki_q_ff    <= '0;
         limit_q_ff <= '0;
         acc_d_ff   <= '0;
         acc_q_ff   <= '0;
         prev_d_ff  <= '0;
         prev_q_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_THREE_PHASE_MODE: mode_ff    <= csr_data[0];
               CSR_KP_D:             kp_d_ff    <= $signed(csr_data);
               CSR_KI_D:             ki_d_ff    <= $signed(csr_data);
               CSR_LIMIT_D:          limit_d_ff <= csr_data[30:0];
               CSR_KP_Q:             kp_q_ff    <= $signed(csr_data);
               CSR_KI_Q:             ki_q_ff    <= $signed(csr_data);
               CSR_LIMIT_Q:          limit_q_ff <= csr_data[30:0];
               default: begin
               end
            endcase
         end
         if (cmd.op == OP_DIFF) begin
            prev_d_ff <= err_d_ff;
            prev_q_ff <= err_q_ff;
         end
         if (cmd.op == OP_CLAMP) begin
            acc_d_ff <= clamp(o_d_ff, limit_d_ff);
            acc_q_ff <= clamp(o_q_ff, limit_q_ff);
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            ia_ff     <= req_phase_a;
            ib_ff     <= req_phase_b;
            ic_ff     <= req_phase_c;
            sector_ff <= req_sector;
            sn_ff     <= req_angle_sine;
            cs_ff     <= req_angle_cosine;
            td_ff     <= req_target_d;
            tq_ff     <= req_target_q;
         end
         OP_RECON: begin
            if (mode_ff) begin
               if (sector_ff == SECTOR_1 || sector_ff == SECTOR_6) begin
                  ia_ff <= -(ib_ff + ic_ff);
               end else if (sector_ff == SECTOR_2 || sector_ff == SECTOR_3) begin
                  ib_ff <= -(ia_ff + ic_ff);
               end else if (sector_ff == SECTOR_4 || sector_ff == SECTOR_5) begin
                  ic_ff <= -(ia_ff + ib_ff);
               end
            end
         end
         OP_CLARKE: begin
            sum_ff <= ia_ff + $signed({ib_ff[30:0], 1'b0});
         end
         OP_MUL: begin
            p_ff <= op_a * op_b;
         end
         OP_ACC: begin
            case (cmd.step)
               STEP_BETA:  be_ff    <= qval;
               STEP_BE_SN: id_ff    <= t_ff + qval;
               STEP_AL_SN: iq_ff    <= t_ff - qval;
               STEP_KI_D:  inc_d_ff <= t_ff + qval;
               STEP_KI_Q:  inc_q_ff <= t_ff + qval;
               STEP_QD_SN: ad_ff    <= t_ff - qval;
               STEP_DD_SN: begin
                  rsp_alpha_drive <= ad_ff;
                  rsp_beta_drive  <= t_ff + qval;
                  rsp_d_current   <= id_ff;
                  rsp_q_current   <= iq_ff;
                  rsp_d_drive     <= acc_d_ff;
                  rsp_q_drive     <= acc_q_ff;
               end
               default: t_ff <= qval;
            endcase
         end
         OP_ERR: begin
            err_d_ff <= td_ff - id_ff;
            err_q_ff <= tq_ff - iq_ff;
         end
         OP_DIFF: begin
            diff_d_ff <= err_d_ff - prev_d_ff;
            diff_q_ff <= err_q_ff - prev_q_ff;
         end
         OP_SUM: begin
            o_d_ff <= acc_d_ff + inc_d_ff;
            o_q_ff <= acc_q_ff + inc_q_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ tb/tb_foc_current_loop.sv @@
// ----------------------------------------------------------------------------
// tb_foc_current_loop
// self-checking bench for the field-oriented current loop: a scoreboard
// predicts reconstruction, clarke, park, both incremental pi regulators and
// inverse park for every accepted transaction and checks each result field.
// directed corner cases come first, then random control periods under
// several gain and limit settings with varying back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_foc_current_loop;
   import foc_pkg::*;

   localparam int FRAC_BITS       = 24;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASES          = 7;
   localparam int SETTLE_CYCLES   = 40;
   localparam int AXIS_D          = 0;
   localparam int AXIS_Q          = 1;
   localparam logic signed [31:0] INV_SQRT3 = 32'(INV_SQRT3_Q32 >> (32 - FRAC_BITS));

   typedef struct {
      logic signed [31:0] phase_a;
      logic signed [31:0] phase_b;
      logic signed [31:0] phase_c;
      logic [2:0]         sector;
      logic signed [31:0] angle_sine;
      logic signed [31:0] angle_cosine;
      logic signed [31:0] target_d;
      logic signed [31:0] target_q;
   } current_sample_type;

   typedef struct {
      logic signed [31:0] alpha_drive;
      logic signed [31:0] beta_drive;
      logic signed [31:0] d_current;
      logic signed [31:0] q_current;
      logic signed [31:0] d_drive;
      logic signed [31:0] q_drive;
   } loop_result_type;

   typedef struct {
      logic               three_phase;
      logic signed [31:0] kp_d;
      logic signed [31:0] ki_d;
      logic [30:0]        limit_d;
      logic signed [31:0] kp_q;
      logic signed [31:0] ki_q;
      logic [30:0]        limit_q;
   } loop_cfg_type;

   class current_loop_scoreboard_type;
      logic               three_phase;
      logic signed [31:0] kp [2];
      logic signed [31:0] ki [2];
      logic [30:0]        limit [2];
      logic signed [31:0] acc [2];
      logic signed [31:0] prev_error [2];
      loop_result_type    expected_drives [$];
      int                 mismatches;

      function new();
         three_phase = 1'b0;
         for (int i = 0; i < 2; i++) begin
            kp[i] = '0;
            ki[i] = '0;
            limit[i] = '0;
            acc[i] = '0;
            prev_error[i] = '0;
         end
         mismatches = 0;
      endfunction

      function void apply_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_THREE_PHASE_MODE: three_phase = data[0];
            CSR_KP_D:             kp[AXIS_D] = data;
            CSR_KI_D:             ki[AXIS_D] = data;
            CSR_LIMIT_D:          limit[AXIS_D] = data[30:0];
            CSR_KP_Q:             kp[AXIS_Q] = data;
            CSR_KI_Q:             ki[AXIS_Q] = data;
            CSR_LIMIT_Q:          limit[AXIS_Q] = data[30:0];
            default: ;
         endcase
      endfunction

      // full product, arithmetic shift (floor), low 32 bits kept
      function logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
         longint prod;
         prod = longint'(a) * longint'(b);
         prod = prod >>> FRAC_BITS;
         return prod[31:0];
      endfunction

      function logic signed [31:0] regulate(int axis, logic signed [31:0] err);
         logic signed [31:0] increment;
         logic signed [31:0] out;
         logic signed [31:0] bound;
         increment = q_mul(kp[axis], err - prev_error[axis]) + q_mul(ki[axis], err);
         out = acc[axis] + increment;
         prev_error[axis] = err;
         bound = {1'b0, limit[axis]};
         if (out > bound) out = bound;
         if (out < -bound) out = -bound;
         acc[axis] = out;
         return out;
      endfunction

      function loop_result_type predict_drive(current_sample_type s);
         logic signed [31:0] ia;
         logic signed [31:0] ib;
         logic signed [31:0] ic;
         logic signed [31:0] beta;
         loop_result_type    r;
         ia = s.phase_a;
         ib = s.phase_b;
         ic = s.phase_c;
         if (three_phase) begin
            case (s.sector)
               3'd1, 3'd6: ia = -ib - ic;
               3'd2, 3'd3: ib = -ia - ic;
               3'd4, 3'd5: ic = -ia - ib;
               default: ;
            endcase
         end
         beta = q_mul(ia + ib + ib, INV_SQRT3);
         r.d_current = q_mul(ia, s.angle_cosine) + q_mul(beta, s.angle_sine);
         r.q_current = q_mul(beta, s.angle_cosine) - q_mul(ia, s.angle_sine);
         r.d_drive = regulate(AXIS_D, s.target_d - r.d_current);
         r.q_drive = regulate(AXIS_Q, s.target_q - r.q_current);
         r.alpha_drive = q_mul(r.d_drive, s.angle_cosine) - q_mul(r.q_drive, s.angle_sine);
         r.beta_drive = q_mul(r.q_drive, s.angle_cosine) + q_mul(r.d_drive, s.angle_sine);
         return r;
      endfunction

      function void note_sample(current_sample_type s);
         expected_drives.push_back(predict_drive(s));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(loop_result_type got);
         loop_result_type want;
         if (expected_drives.size() == 0) begin
            $display("%0t: unexpected result: expected none actual alpha %h beta %h d %h q %h",
                     $time, got.alpha_drive, got.beta_drive, got.d_drive, got.q_drive);
            mismatches++;
            return;
         end
         want = expected_drives.pop_front();
         compare_field("alpha_drive", want.alpha_drive, got.alpha_drive);
         compare_field("beta_drive", want.beta_drive, got.beta_drive);
         compare_field("d_current", want.d_current, got.d_current);
         compare_field("q_current", want.q_current, got.q_current);
         compare_field("d_drive", want.d_drive, got.d_drive);
         compare_field("q_drive", want.q_drive, got.q_drive);
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [31:0]          req_phase_a = '0;
   logic signed [31:0]          req_phase_b = '0;
   logic signed [31:0]          req_phase_c = '0;
   logic [2:0]                  req_sector = '0;
   logic signed [31:0]          req_angle_sine = '0;
   logic signed [31:0]          req_angle_cosine = '0;
   logic signed [31:0]          req_target_d = '0;
   logic signed [31:0]          req_target_q = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [31:0]          rsp_alpha_drive;
   logic signed [31:0]          rsp_beta_drive;
   logic signed [31:0]          rsp_d_current;
   logic signed [31:0]          rsp_q_current;
   logic signed [31:0]          rsp_d_drive;
   logic signed [31:0]          rsp_q_drive;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data = '0;

   int                          send_idle_pct = 9;
   int                          recv_idle_pct = 83;
   loop_result_type             observed;
   current_loop_scoreboard_type scoreboard = new();

   foc_current_loop #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_phase_a(req_phase_a),
      .req_phase_b(req_phase_b),
      .req_phase_c(req_phase_c),
      .req_sector(req_sector),
      .req_angle_sine(req_angle_sine),
      .req_angle_cosine(req_angle_cosine),
      .req_target_d(req_target_d),
      .req_target_q(req_target_q),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_alpha_drive(rsp_alpha_drive),
      .rsp_beta_drive(rsp_beta_drive),
      .rsp_d_current(rsp_d_current),
      .rsp_q_current(rsp_q_current),
      .rsp_d_drive(rsp_d_drive),
      .rsp_q_drive(rsp_q_drive),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.alpha_drive = rsp_alpha_drive;
         observed.beta_drive = rsp_beta_drive;
         observed.d_current = rsp_d_current;
         observed.q_current = rsp_q_current;
         observed.d_drive = rsp_d_drive;
         observed.q_drive = rsp_q_drive;
         scoreboard.check_result(observed);
      end
   end

   function automatic logic signed [31:0] scaled_random(int bits);
      logic signed [31:0] v;
      v = $urandom;
      return v >>> (32 - bits);
   endfunction

   function automatic current_sample_type make_sample(
      logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c, logic [2:0] sector,
      logic signed [31:0] sn, logic signed [31:0] cs, logic signed [31:0] td,
      logic signed [31:0] tq);
      current_sample_type s;
      s.phase_a = a;
      s.phase_b = b;
      s.phase_c = c;
      s.sector = sector;
      s.angle_sine = sn;
      s.angle_cosine = cs;
      s.target_d = td;
      s.target_q = tq;
      return s;
   endfunction

   // mostly plausible control periods, some fully random ones
   function automatic current_sample_type random_sample();
      current_sample_type s;
      if ($urandom_range(3) == 0) begin
         s = make_sample($urandom, $urandom, $urandom, 3'($urandom_range(7)),
                         $urandom, $urandom, $urandom, $urandom);
      end else begin
         s.phase_a = scaled_random(27);
         s.phase_b = scaled_random(27);
         s.phase_c = ($urandom_range(1) == 0) ? -s.phase_a - s.phase_b : scaled_random(27);
         s.sector = 3'($urandom_range(7));
         s.angle_sine = scaled_random(26);
         s.angle_cosine = scaled_random(26);
         s.target_d = scaled_random(27);
         s.target_q = scaled_random(27);
      end
      return s;
   endfunction

   function automatic logic signed [31:0] random_gain();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $urandom;
         default: return scaled_random(26);
      endcase
   endfunction

   function automatic logic [30:0] random_limit();
      case ($urandom_range(9))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         default: return 31'($urandom_range(32'h0800_0000, 32'h0010_0000));
      endcase
   endfunction

   function automatic loop_cfg_type random_config();
      loop_cfg_type cfg;
      cfg.three_phase = ($urandom_range(3) != 0);
      cfg.kp_d = random_gain();
      cfg.ki_d = random_gain();
      cfg.limit_d = random_limit();
      cfg.kp_q = random_gain();
      cfg.ki_q = random_gain();
      cfg.limit_q = random_limit();
      return cfg;
   endfunction

   task automatic put_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      scoreboard.apply_csr(idx, data);
   endtask

   task automatic load_config(input loop_cfg_type cfg);
      put_csr(CSR_THREE_PHASE_MODE, {31'd0, cfg.three_phase});
      put_csr(CSR_KP_D, cfg.kp_d);
      put_csr(CSR_KI_D, cfg.ki_d);
      put_csr(CSR_LIMIT_D, {1'b0, cfg.limit_d});
      put_csr(CSR_KP_Q, cfg.kp_q);
      put_csr(CSR_KI_Q, cfg.ki_q);
      put_csr(CSR_LIMIT_Q, {1'b0, cfg.limit_q});
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_sample(input current_sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_phase_a <= s.phase_a;
      req_phase_b <= s.phase_b;
      req_phase_c <= s.phase_c;
      req_sector <= s.sector;
      req_angle_sine <= s.angle_sine;
      req_angle_cosine <= s.angle_cosine;
      req_target_d <= s.target_d;
      req_target_q <= s.target_q;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_sample(s);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending() != 0);
   endtask

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: mode off, limits zero force drives to zero
      send_sample(make_sample(0, 0, 0, 3'd0, 0, 0, 0, 0));
      send_sample(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 3'd7,
                              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_sample(make_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 3'd0,
                              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
      send_sample(make_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 3'd1,
                              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
      send_sample(make_sample(32'sd25165824, -32'sd16777216, 32'sd20971520, 3'd3,
                              32'sd11863283, 32'sd11863283, 32'sd16777216, -32'sd8388608));
      send_sample(make_sample(32'sd25165824, -32'sd16777216, 32'sd20971520, 3'd5,
                              32'sd11863283, -32'sd11863283, 32'sd16777216, -32'sd8388608));

      // mode on, moderate gains: every sector
      wait_for_results();
      load_config('{three_phase: 1'b1, kp_d: 32'sd8388608, ki_d: 32'sd1048576,
                    limit_d: 31'd33554432, kp_q: 32'sd8388608, ki_q: 32'sd1048576,
                    limit_q: 31'd33554432});
      for (int s = 0; s < 8; s++) begin
         send_sample(make_sample(32'sd25165824, -32'sd16777216, 32'sd20971520, 3'(s),
                                 32'sd11863283, 32'sd11863283, 32'sd16777216, -32'sd8388608));
      end
      // wrapping sums in reconstruction and clarke
      send_sample(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 3'd2,
                              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
      send_sample(make_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 3'd6,
                              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));

      // extreme gains, one axis unlimited and the other held at zero
      wait_for_results();
      load_config('{three_phase: 1'b1, kp_d: 32'sh7FFF_FFFF, ki_d: 32'sh8000_0000,
                    limit_d: 31'h7FFF_FFFF, kp_q: 32'sh8000_0000, ki_q: 32'sh7FFF_FFFF,
                    limit_q: 31'd0});
      send_sample(make_sample(32'sd16777216, 32'sd8388608, -32'sd25165824, 3'd4,
                              32'sd16777216, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
      send_sample(make_sample(-32'sd16777216, 32'sd8388608, 32'sd8388608, 3'd1,
                              0, 32'sd16777216, 32'sh8000_0000, 32'sh7FFF_FFFF));
      send_sample(make_sample(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 3'd0,
                              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0));
      wait_for_results();
      load_config('{three_phase: 1'b0, kp_d: 32'sh8000_0000, ki_d: 32'sh7FFF_FFFF,
                    limit_d: 31'd0, kp_q: 32'sh7FFF_FFFF, ki_q: 32'sh8000_0000,
                    limit_q: 31'h7FFF_FFFF});
      send_sample(make_sample(32'sd16777216, 32'sd8388608, -32'sd25165824, 3'd4,
                              32'sd16777216, 32'sd16777216, 32'sh7FFF_FFFF, 32'sh8000_0000));
      send_sample(make_sample(-32'sd16777216, 32'sd8388608, 32'sd8388608, 3'd2,
                              32'sh8000_0000, 32'sd16777216, 32'sh8000_0000, 32'sh7FFF_FFFF));

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_for_results();
         load_config(random_config());
         send_idle_pct = (ph < 3) ? 9 : (ph < 5) ? 83 : 0;
         recv_idle_pct = (ph < 3) ? 83 : (ph < 5) ? 9 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 0 && n == ITEMS_PER_PHASE / 2) wait_for_results();
            send_sample(random_sample());
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
